@@ rtl/edid_base_block_timing_filter_top_assert.svh @@
// ----------------------------------------------------------------------------
// EDID timing filter assertion macros
// Shared assertion forms for the checker of the EDID timing filter.
// ----------------------------------------------------------------------------
`ifndef EDID_BASE_BLOCK_TIMING_FILTER_TOP_ASSERT_SVH
`define EDID_BASE_BLOCK_TIMING_FILTER_TOP_ASSERT_SVH

// Assertion that is switched off while reset is high.
`define EBTF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Assertion that also holds across reset.
`define EBTF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

@@ rtl/ebtf_pkg.sv @@
// ----------------------------------------------------------------------------
// EDID timing filter package
// Types, constants and byte rewrite functions shared by the filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ebtf_pkg;

   localparam int BLOCK_BYTES = 128;
   localparam int IDX_W       = $clog2(BLOCK_BYTES);
   localparam int DESC_FIRST  = 54;
   localparam int DESC_STRIDE = 18;
   localparam int DESC_COUNT  = 4;
   localparam int DESC_HELD   = 8;
   localparam int OFF_W       = $clog2(DESC_HELD);
   localparam int DIM_W       = 12;
   localparam int AREA_W      = 2 * DIM_W;
   localparam int TOT_W       = DIM_W + 1;

   localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(BLOCK_BYTES - 1);
   localparam logic [IDX_W-1:0] IDX_ESTAB0  = IDX_W'(35);
   localparam logic [IDX_W-1:0] IDX_ESTAB1  = IDX_W'(36);
   localparam logic [IDX_W-1:0] IDX_ESTAB2  = IDX_W'(37);
   localparam logic [IDX_W-1:0] IDX_STD_LO  = IDX_W'(38);
   localparam logic [IDX_W-1:0] IDX_STD_HI  = IDX_W'(53);
   localparam logic [IDX_W-1:0] IDX_FIX_LO  = IDX_W'(54);
   localparam logic [IDX_W-1:0] IDX_FIX_HI  = IDX_W'(61);
   localparam logic [OFF_W-1:0] OFF_LAST    = OFF_W'(DESC_HELD - 1);

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_PASS      = 2'd0;
   localparam mode_type MODE_FULL      = 2'd1;
   localparam mode_type MODE_FIXED_800 = 2'd2;
   localparam mode_type MODE_FIXED_640 = 2'd3;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HEIGHT  = 2'd2;

   localparam logic [DIM_W-1:0] MAX_WIDTH_RESET  = 12'd1920;
   localparam logic [DIM_W-1:0] MAX_HEIGHT_RESET = 12'd1080;

   localparam logic [7:0] EST_FULL_0  = 8'h21;
   localparam logic [7:0] EST_FULL_1  = 8'h08;
   localparam logic [7:0] EST_ZERO    = 8'h00;
   localparam logic [7:0] EST_800     = 8'h01;
   localparam logic [7:0] EST_640     = 8'h20;
   localparam logic [7:0] STD_UNUSED  = 8'h01;
   localparam logic [7:0] H_BLANK     = 8'd128;
   localparam logic [7:0] V_BLANK     = 8'd32;

   localparam logic [7:0] FIXED_800 [DESC_HELD] =
      '{8'h40, 8'h0B, 8'h20, 8'h00, 8'h30, 8'h58, 8'h00, 8'h20};
   localparam logic [7:0] FIXED_640 [DESC_HELD] =
      '{8'h3F, 8'h07, 8'h80, 8'h00, 8'h20, 8'hE0, 8'h00, 8'h10};

   // Pixel clock in 10 kHz units is P * 60 / 10000 = ((3 * P) >> 2) / 125.
   // The division by 125 is a multiply by ceil(2^32 / 125) and a shift.
   localparam int MUL_A_W     = 24;
   localparam int MUL_B_W     = 26;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
   localparam int CLK_PROD_W  = 25;
   localparam int RECIP_SHIFT = 32;
   localparam int PCLK_W      = 16;
   localparam logic [MUL_B_W-1:0] RECIP_MULT = 26'd34359739;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_CHECK,
      KIND_STORE,
      KIND_LAST
   } kind_type;

   typedef enum logic [1:0] {
      MUL_AREA,
      MUL_LIMIT,
      MUL_CLOCK,
      MUL_RECIP
   } mul_sel_type;

   typedef struct packed {
      logic        load_in;
      logic        commit;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        cap_area;
      logic        cap_limit;
      logic        fix;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     out_free;
      logic     emit_last;
   } status_type;

   typedef struct packed {
      logic             hit;
      logic [OFF_W-1:0] off;
   } slot_type;

   function automatic slot_type desc_slot(input logic [IDX_W-1:0] idx);
      slot_type s;
      int       base;
      s = '0;
      for (int k = 0; k < DESC_COUNT; k++) begin
         base = DESC_FIRST + k * DESC_STRIDE;
         if (int'(idx) >= base && int'(idx) < base + DESC_HELD) begin
            s.hit = 1'b1;
            s.off = OFF_W'(int'(idx) - base);
         end
      end
      return s;
   endfunction

   function automatic logic [7:0] rewrite(input mode_type         mode,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [7:0]       b);
      logic [7:0]       r;
      logic [OFF_W-1:0] t;
      r = b;
      t = OFF_W'(idx - IDX_FIX_LO);
      case (mode)
         MODE_FULL: begin
            if (idx == IDX_ESTAB0) r = EST_FULL_0;
            else if (idx == IDX_ESTAB1) r = EST_FULL_1;
            else if (idx == IDX_ESTAB2) r = EST_ZERO;
         end
         MODE_FIXED_800, MODE_FIXED_640: begin
            if (idx == IDX_ESTAB0) begin
               r = (mode == MODE_FIXED_800) ? EST_800 : EST_640;
            end else if (idx == IDX_ESTAB1 || idx == IDX_ESTAB2) begin
               r = EST_ZERO;
            end else if (idx inside {[IDX_STD_LO:IDX_STD_HI]}) begin
               r = STD_UNUSED;
            end else if (idx inside {[IDX_FIX_LO:IDX_FIX_HI]}) begin
               r = (mode == MODE_FIXED_800) ? FIXED_800[t] : FIXED_640[t];
            end
         end
         default: r = b;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/edid_base_block_timing_filter_top.sv @@
// ----------------------------------------------------------------------------
// EDID base block timing filter
// Rewrites an EDID base block byte by byte and regenerates its checksum.
// ----------------------------------------------------------------------------
// A passed byte goes through the input register and, once the output register
// is free, into the output register; a new request is taken only when the last
// is done. A held descriptor's last byte adds the area, limit, clock and
// reciprocal products on the shared multiplier, a fix and an eight-byte flush.
// Reset clears the byte index, checksum, scan state and output valid bit;
// the limits return to 1920 by 1080 and the mode to pass through.
`default_nettype none

module edid_base_block_timing_filter_top import ebtf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_edid_byte,
   input  logic                  req_block_start,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_run_last,
   output logic                  rsp_block_end,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type stat;

   assign csr_ready = 1'b1;

   ebtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ebtf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_edid_byte   (req_edid_byte),
      .req_block_start (req_block_start),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_block_end   (rsp_block_end)
   );

endmodule

`default_nettype wire

@@ rtl/ebtf_ctrl.sv @@
// ----------------------------------------------------------------------------
// EDID timing filter controller
// Sequences request intake, descriptor evaluation and the eight-byte flush.
// ----------------------------------------------------------------------------
`default_nettype none

module ebtf_ctrl import ebtf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type stat,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_M_AREA,
      ST_M_LIMIT,
      ST_M_CLOCK,
      ST_M_RECIP,
      ST_FIX,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   assign req_ready = req_ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_in = req_valid && req_ready_ff;
            if (req_valid && req_ready_ff) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (stat.kind inside {KIND_STORE, KIND_LAST} || stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = (stat.kind == KIND_LAST) ? ST_M_AREA : ST_IDLE;
            end
         end
         ST_M_AREA: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_AREA;
            state_in    = ST_M_LIMIT;
         end
         ST_M_LIMIT: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_LIMIT;
            cmd.cap_area = 1'b1;
            state_in     = ST_M_CLOCK;
         end
         ST_M_CLOCK: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_CLOCK;
            cmd.cap_limit = 1'b1;
            state_in      = ST_M_RECIP;
         end
         ST_M_RECIP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RECIP;
            state_in    = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.emit_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

endmodule

`default_nettype wire

@@ rtl/ebtf_datapath.sv @@
// ----------------------------------------------------------------------------
// EDID timing filter datapath
// Byte index, checksum, descriptor hold registers, shared multiplier and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ebtf_datapath import ebtf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_edid_byte,
   input  logic                  req_block_start,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output status_type            stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_run_last,
   output logic                  rsp_block_end
);

   mode_type          mode_ff;
   logic [DIM_W-1:0]  max_w_ff;
   logic [DIM_W-1:0]  max_h_ff;

   logic [7:0]        in_byte_ff;
   logic              in_start_ff;
   logic [IDX_W-1:0]  index_ff;
   logic [7:0]        sum_ff;
   logic              scan_ff;
   logic              holding_ff;
   logic [7:0]        hold_ff [DESC_HELD];
   logic [OFF_W-1:0]  emit_cnt_ff;
   logic [MUL_P_W-1:0] mul_ff;
   logic [AREA_W-1:0] area_ff;
   logic [AREA_W-1:0] limit_ff;

   logic              rsp_valid_ff;
   logic [7:0]        out_byte_ff;
   logic              run_last_ff;
   logic              block_end_ff;

   logic [IDX_W-1:0]  idx;
   logic              first;
   logic [7:0]        sum_eff;
   logic              scan_eff;
   logic              holding_eff;
   logic              hold_now;
   slot_type          slot;
   kind_type          kind;
   logic [7:0]        plain_byte;
   logic [7:0]        check_byte;
   logic [7:0]        emit_byte;
   logic              out_free;

   logic [DIM_W-1:0]   h_act;
   logic [DIM_W-1:0]   v_act;
   logic [TOT_W-1:0]   h_tot;
   logic [TOT_W-1:0]   v_tot;
   logic [MUL_B_W-1:0] clk_x3;
   logic [MUL_A_W-1:0] op_a;
   logic [MUL_B_W-1:0] op_b;
   logic [MUL_P_W-RECIP_SHIFT-1:0] quot;
   logic [PCLK_W-1:0]  pclk;
   logic               desc_zero;
   logic               desc_big;

   logic [7:0]         sum_in;
   logic               load_out;
   logic [7:0]         out_byte_in;
   logic               run_last_in;
   logic               block_end_in;

   assign idx         = in_start_ff ? '0 : index_ff;
   assign first       = (idx == '0);
   assign sum_eff     = first ? 8'd0 : sum_ff;
   assign scan_eff    = first ? 1'b0 : scan_ff;
   assign holding_eff = first ? 1'b0 : holding_ff;
   assign slot        = desc_slot(idx);
   assign hold_now    = (slot.off == '0) ? (mode_ff == MODE_FULL && !scan_eff) : holding_eff;
   assign plain_byte  = rewrite(mode_ff, idx, in_byte_ff);
   assign check_byte  = 8'd0 - sum_eff;
   assign emit_byte   = hold_ff[emit_cnt_ff];
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (idx == IDX_LAST) kind = KIND_CHECK;
      else if (slot.hit && hold_now) kind = (slot.off == OFF_LAST) ? KIND_LAST : KIND_STORE;
      else kind = KIND_PLAIN;
   end

   assign stat.kind      = kind;
   assign stat.out_free  = out_free;
   assign stat.emit_last = (emit_cnt_ff == OFF_LAST);

   assign h_act  = {hold_ff[4][7:4], hold_ff[2]};
   assign v_act  = {hold_ff[7][7:4], hold_ff[5]};
   assign h_tot  = TOT_W'(max_w_ff) + TOT_W'(H_BLANK);
   assign v_tot  = TOT_W'(max_h_ff) + TOT_W'(V_BLANK);
   assign clk_x3 = MUL_B_W'({mul_ff[CLK_PROD_W-1:0], 1'b0}) + MUL_B_W'(mul_ff[CLK_PROD_W-1:0]);

   always_comb begin
      case (cmd.mul_sel)
         MUL_AREA: begin
            op_a = MUL_A_W'(h_act);
            op_b = MUL_B_W'(v_act);
         end
         MUL_LIMIT: begin
            op_a = MUL_A_W'(max_w_ff);
            op_b = MUL_B_W'(max_h_ff);
         end
         MUL_CLOCK: begin
            op_a = MUL_A_W'(h_tot);
            op_b = MUL_B_W'(v_tot);
         end
         MUL_RECIP: begin
            op_a = clk_x3[MUL_B_W-1:2];
            op_b = RECIP_MULT;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign quot      = mul_ff[MUL_P_W-1:RECIP_SHIFT];
   assign pclk      = (|quot[MUL_P_W-RECIP_SHIFT-1:PCLK_W]) ? '1 : quot[PCLK_W-1:0];
   assign desc_zero = (hold_ff[0] == 8'd0) && (hold_ff[1] == 8'd0);
   assign desc_big  = (area_ff > limit_ff);

   always_comb begin
      sum_in       = sum_ff;
      load_out     = 1'b0;
      out_byte_in  = out_byte_ff;
      run_last_in  = run_last_ff;
      block_end_in = block_end_ff;
      if (cmd.commit) begin
         sum_in = sum_eff;
         if (kind == KIND_PLAIN) begin
            sum_in       = sum_eff + plain_byte;
            load_out     = 1'b1;
            out_byte_in  = plain_byte;
            run_last_in  = 1'b1;
            block_end_in = 1'b0;
         end else if (kind == KIND_CHECK) begin
            load_out     = 1'b1;
            out_byte_in  = check_byte;
            run_last_in  = 1'b1;
            block_end_in = 1'b1;
         end
      end else if (cmd.emit) begin
         sum_in       = sum_ff + emit_byte;
         load_out     = 1'b1;
         out_byte_in  = emit_byte;
         run_last_in  = (emit_cnt_ff == OFF_LAST);
         block_end_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PASS;
         max_w_ff     <= MAX_WIDTH_RESET;
         max_h_ff     <= MAX_HEIGHT_RESET;
         index_ff     <= '0;
         sum_ff       <= '0;
         scan_ff      <= 1'b0;
         holding_ff   <= 1'b0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_FILTER_MODE: mode_ff  <= csr_wdata[1:0];
               CSR_MAX_WIDTH:   max_w_ff <= csr_wdata;
               CSR_MAX_HEIGHT:  max_h_ff <= csr_wdata;
               default: ;
            endcase
         end
         sum_ff <= sum_in;
         if (cmd.commit) begin
            index_ff    <= idx + IDX_W'(1);
            scan_ff     <= scan_eff;
            emit_cnt_ff <= '0;
            if (kind == KIND_LAST) holding_ff <= 1'b0;
            else if (slot.hit && slot.off == '0) holding_ff <= hold_now;
            else holding_ff <= holding_eff;
         end
         if (cmd.fix && desc_zero) scan_ff <= 1'b1;
         if (cmd.emit) emit_cnt_ff <= emit_cnt_ff + OFF_W'(1);
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_byte_ff  <= req_edid_byte;
         in_start_ff <= req_block_start;
      end
      if (cmd.commit && (kind == KIND_STORE || kind == KIND_LAST)) begin
         hold_ff[slot.off] <= in_byte_ff;
      end
      if (cmd.fix && !desc_zero && desc_big) begin
         hold_ff[0] <= pclk[7:0];
         hold_ff[1] <= pclk[15:8];
         hold_ff[2] <= max_w_ff[7:0];
         hold_ff[3] <= H_BLANK;
         hold_ff[4] <= {max_w_ff[DIM_W-1:8], 4'h0};
         hold_ff[5] <= max_h_ff[7:0];
         hold_ff[6] <= V_BLANK;
         hold_ff[7] <= {max_h_ff[DIM_W-1:8], 4'h0};
      end
      if (cmd.mul_en) mul_ff <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
      if (cmd.cap_area) area_ff <= mul_ff[AREA_W-1:0];
      if (cmd.cap_limit) limit_ff <= mul_ff[AREA_W-1:0];
      if (load_out) begin
         out_byte_ff  <= out_byte_in;
         run_last_ff  <= run_last_in;
         block_end_ff <= block_end_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_block_end = block_end_ff;

endmodule

`default_nettype wire

@@ rtl/ebtf_checker.sv @@
// ----------------------------------------------------------------------------
// EDID timing filter checker
// Port-level assertions on the filter top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "edid_base_block_timing_filter_top_assert.svh"

module ebtf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_block_end
);

   `EBTF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last) && $stable(rsp_block_end), "Stalled response changed.")

   `EBTF_ASSERT(a_end_is_last, clock, reset, rsp_valid && rsp_block_end |-> rsp_run_last, "Checksum byte is not the last of its request.")

   `EBTF_ASSERT(a_req_spacing, clock, reset, req_valid && req_ready |=> !req_ready, "Request accepted in back-to-back cycles.")

   `EBTF_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && !req_ready, "Block not idle after reset.")

endmodule

bind edid_base_block_timing_filter_top ebtf_checker u_ebtf_checker (.*);

`default_nettype wire
